[src/eld_pkg.sv]
package eld_pkg;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_UNKNOWN = 3'd1;
   localparam logic [2:0] STATUS_OCT_OVF = 3'd2;
   localparam logic [2:0] STATUS_HEX_OVF = 3'd3;
   localparam logic [2:0] STATUS_NEWLINE = 3'd4;
   localparam logic [2:0] STATUS_EOI     = 3'd5;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_QMARK     = 8'h3F;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_VT        = 8'h0B;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_FF        = 8'h0C;
   localparam logic [7:0] CHAR_BEL       = 8'h07;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;

   localparam logic [7:0] LETTER_T = 8'h74;
   localparam logic [7:0] LETTER_N = 8'h6E;
   localparam logic [7:0] LETTER_R = 8'h72;
   localparam logic [7:0] LETTER_V = 8'h76;
   localparam logic [7:0] LETTER_B = 8'h62;
   localparam logic [7:0] LETTER_F = 8'h66;
   localparam logic [7:0] LETTER_A = 8'h61;
   localparam logic [7:0] LETTER_X = 8'h78;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       quote_is_double;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic [7:0] char_code;
      logic       char_done;
      logic       literal_done;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] code;
      logic [2:0] status;
      logic       verbatim;
      logic       ends;
   } char_type;

   typedef struct packed {
      logic     eoi;
      logic     two_chars;
      char_type c0;
      char_type c1;
   } job_type;

   typedef struct packed {
      logic char_fin;
      logic job_last;
   } step_type;

endpackage

[src/eld_decode.sv]
module eld_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  eld_pkg::req_type req,
   output logic             has_job,
   output eld_pkg::job_type job
);
   import eld_pkg::*;

   typedef enum logic [1:0] {MODE_PLAIN, MODE_ESC, MODE_OCT, MODE_HEX} mode_type;

   typedef struct packed {
      logic     has;
      char_type ch;
      logic     to_esc;
   } plain_type;

   mode_type    mode_ff;
   mode_type    mode_in;
   logic [7:0]  code_ff;
   logic [7:0]  code_in;
   logic [7:0]  term;
   plain_type   plain;
   logic        is_oct;
   logic        digit_ok;
   logic [3:0]  digit;
   logic [11:0] value;
   logic        overflow;
   logic        esc_known;
   logic [7:0]  esc_code;

   function automatic plain_type plain_step(input logic [7:0] c, input logic [7:0] t);
      plain_type p;
      p = '0;
      if (c == CHAR_NEWLINE) begin
         p.has       = 1'b1;
         p.ch.code   = CHAR_QMARK;
         p.ch.status = STATUS_NEWLINE;
         p.ch.ends   = 1'b1;
      end else if (c == CHAR_BACKSLASH) begin
         p.to_esc = 1'b1;
      end else begin
         p.has         = 1'b1;
         p.ch.code     = c;
         p.ch.status   = STATUS_OK;
         p.ch.verbatim = (c == t);
         p.ch.ends     = (c == t);
      end
      return p;
   endfunction

   always_comb begin
      term   = req.quote_is_double ? CHAR_DQUOTE : CHAR_SQUOTE;
      plain  = plain_step(req.in_byte, term);
      is_oct = (mode_ff == MODE_OCT);

      esc_known = 1'b1;
      esc_code  = 8'd0;
      case (req.in_byte)
         LETTER_T: esc_code = CHAR_TAB;
         LETTER_N: esc_code = CHAR_NEWLINE;
         LETTER_A: esc_code = CHAR_BEL;
         LETTER_R: esc_code = CHAR_CR;
         LETTER_F: esc_code = CHAR_FF;
         LETTER_B: esc_code = CHAR_BS;
         LETTER_V: esc_code = CHAR_VT;
         CHAR_BACKSLASH: esc_code = CHAR_BACKSLASH;
         CHAR_SQUOTE: esc_code = CHAR_SQUOTE;
         CHAR_DQUOTE: esc_code = CHAR_DQUOTE;
         default: esc_known = 1'b0;
      endcase

      digit_ok = 1'b0;
      digit    = req.in_byte[3:0];
      if (is_oct) begin
         digit_ok = (req.in_byte[7:3] == 5'b00110);
         digit    = {1'b0, req.in_byte[2:0]};
      end else if (req.in_byte >= 8'h30 && req.in_byte <= 8'h39) begin
         digit_ok = 1'b1;
      end else if ((req.in_byte >= 8'h61 && req.in_byte <= 8'h66) ||
                   (req.in_byte >= 8'h41 && req.in_byte <= 8'h46)) begin
         digit_ok = 1'b1;
         digit    = req.in_byte[3:0] + 4'd9;
      end
      value    = is_oct ? {1'b0, code_ff, digit[2:0]} : {code_ff, digit};
      overflow = (value[11:8] != 4'd0);

      has_job = 1'b0;
      job     = '0;
      mode_in = mode_ff;
      code_in = code_ff;
      if (req.end_of_input) begin
         has_job = 1'b1;
         job.eoi = 1'b1;
         mode_in = MODE_PLAIN;
         code_in = 8'd0;
      end else begin
         case (mode_ff)
            MODE_PLAIN: begin
               has_job = plain.has;
               job.c0  = plain.ch;
               if (req.in_byte == CHAR_NEWLINE) begin
                  code_in = 8'd0;
               end
               if (plain.to_esc) begin
                  mode_in = MODE_ESC;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_PLAIN;
               if (esc_known) begin
                  has_job       = 1'b1;
                  job.c0.code   = esc_code;
                  job.c0.status = STATUS_OK;
               end else if (req.in_byte[7:3] == 5'b00110) begin
                  mode_in = MODE_OCT;
                  code_in = {5'd0, req.in_byte[2:0]};
               end else if (req.in_byte == LETTER_X) begin
                  mode_in = MODE_HEX;
                  code_in = 8'd0;
               end else begin
                  has_job       = 1'b1;
                  job.c0.code   = CHAR_QMARK;
                  job.c0.status = STATUS_UNKNOWN;
               end
            end
            default: begin
               if (!digit_ok || overflow) begin
                  has_job       = 1'b1;
                  job.c0.code   = digit_ok ? value[7:0] : code_ff;
                  job.c0.status = !digit_ok ? STATUS_OK :
                                  (is_oct ? STATUS_OCT_OVF : STATUS_HEX_OVF);
                  job.two_chars = plain.has;
                  job.c1        = plain.ch;
                  mode_in       = plain.to_esc ? MODE_ESC : MODE_PLAIN;
                  code_in       = 8'd0;
               end else begin
                  code_in = value[7:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         code_ff <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         code_ff <= code_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_PLAIN || mode_ff == MODE_ESC) |-> code_ff == 8'd0)
      else $error("Code is not clear outside a numeric escape.");

   assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_input |=> mode_ff == MODE_PLAIN && code_ff == 8'd0)
      else $error("End of input did not return the decoder to plain mode.");

   assert property (@(posedge clock) disable iff (reset)
      has_job && job.two_chars |-> !job.eoi && (mode_ff == MODE_OCT || mode_ff == MODE_HEX))
      else $error("Two characters decoded outside a numeric escape.");

endmodule

[src/eld_expand.sv]
module eld_expand (
   input  logic              char_sel,
   input  logic [1:0]        byte_idx,
   input  eld_pkg::job_type  job,
   output eld_pkg::rsp_type  result,
   output eld_pkg::step_type step
);
   import eld_pkg::*;

   typedef struct packed {
      logic [1:0]      len_m1;
      logic [3:0][7:0] bytes;
   } spell_type;

   char_type  ch;
   spell_type sp;
   logic      fin;
   logic      more;

   function automatic spell_type spell(input char_type c);
      spell_type s;
      s          = '0;
      s.bytes[0] = CHAR_BACKSLASH;
      if (c.verbatim) begin
         s.bytes[0] = c.code;
      end else if (c.code == CHAR_BACKSLASH || c.code == CHAR_SQUOTE ||
                   c.code == CHAR_DQUOTE) begin
         s.len_m1   = 2'd1;
         s.bytes[1] = c.code;
      end else if (c.code >= CHAR_SPACE && c.code < CHAR_DEL) begin
         s.bytes[0] = c.code;
      end else begin
         s.len_m1 = 2'd1;
         case (c.code)
            CHAR_TAB:     s.bytes[1] = LETTER_T;
            CHAR_NEWLINE: s.bytes[1] = LETTER_N;
            CHAR_CR:      s.bytes[1] = LETTER_R;
            CHAR_VT:      s.bytes[1] = LETTER_V;
            CHAR_BS:      s.bytes[1] = LETTER_B;
            CHAR_FF:      s.bytes[1] = LETTER_F;
            default: begin
               s.len_m1   = 2'd3;
               s.bytes[1] = CHAR_ZERO + {6'd0, c.code[7:6]};
               s.bytes[2] = CHAR_ZERO + {5'd0, c.code[5:3]};
               s.bytes[3] = CHAR_ZERO + {5'd0, c.code[2:0]};
            end
         endcase
      end
      return s;
   endfunction

   always_comb begin
      ch   = char_sel ? job.c1 : job.c0;
      sp   = spell(ch);
      fin  = (byte_idx == sp.len_m1);
      more = !char_sel && job.two_chars;
      if (job.eoi) begin
         result              = '0;
         result.literal_done = 1'b1;
         result.status       = STATUS_EOI;
         result.last         = 1'b1;
         step.char_fin       = 1'b1;
         step.job_last       = 1'b1;
      end else begin
         result.byte_valid   = 1'b1;
         result.out_byte     = sp.bytes[byte_idx];
         result.char_code    = ch.code;
         result.char_done    = fin;
         result.literal_done = fin && ch.ends;
         result.status       = ch.status;
         result.last         = fin && !more;
         step.char_fin       = fin;
         step.job_last       = fin && !more;
      end
   end

endmodule

[src/escaped_literal_decoder.sv]
// Channel   Direction  Handshake          Word
// req       in         req_valid/stall    eld_pkg::req_type, one raw byte of the literal
// rsp       out        rsp_valid/stall    eld_pkg::rsp_type, one byte of canonical spelling
//
// An accepted word is decoded in the cycle it arrives and any job it yields is held in a
// job register. While the output is not stalled, each following cycle sends one spelling
// byte to the output register; a job yields one to eight bytes, an end-of-input job none.
// The input is stalled while a job still has bytes to send after this cycle.
// Reset is synchronous and returns the decoder to plain mode with an empty pipeline.
module escaped_literal_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  eld_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output eld_pkg::rsp_type rsp_data
);
   import eld_pkg::*;

   logic     accept;
   logic     has_job;
   job_type  job;
   job_type  job_ff;
   logic     job_valid_ff;
   logic     job_valid_in;
   logic     char_sel_ff;
   logic     char_sel_in;
   logic [1:0] byte_idx_ff;
   logic [1:0] byte_idx_in;
   rsp_type  result;
   step_type step;
   rsp_type  rsp_data_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     out_free;
   logic     advance;
   logic     job_done;

   eld_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .has_job (has_job),
      .job     (job)
   );

   eld_expand u_expand (
      .char_sel (char_sel_ff),
      .byte_idx (byte_idx_ff),
      .job      (job_ff),
      .result   (result),
      .step     (step)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = job_valid_ff && out_free;
      job_done  = advance && step.job_last;
      req_stall = job_valid_ff && !job_done;
      accept    = req_valid && !req_stall;

      job_valid_in = job_valid_ff;
      char_sel_in  = char_sel_ff;
      byte_idx_in  = byte_idx_ff;
      if (accept && has_job) begin
         job_valid_in = 1'b1;
         char_sel_in  = 1'b0;
         byte_idx_in  = 2'd0;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (advance) begin
         if (step.char_fin) begin
            char_sel_in = 1'b1;
            byte_idx_in = 2'd0;
         end else begin
            byte_idx_in = byte_idx_ff + 2'd1;
         end
      end
      rsp_valid_in = out_free ? job_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         char_sel_ff  <= 1'b0;
         byte_idx_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         char_sel_ff  <= char_sel_in;
         byte_idx_ff  <= byte_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_job) begin
         job_ff <= job;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept && has_job |=> job_valid_ff && !char_sel_ff && byte_idx_ff == 2'd0)
      else $error("A new job did not start at its first byte.");

   assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && char_sel_ff |-> job_ff.two_chars && !job_ff.eoi)
      else $error("Second character selected in a job that has none.");

   assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && job_ff.eoi |-> step.job_last && byte_idx_ff == 2'd0)
      else $error("End of input job yields more than one word.");

   assert property (@(posedge clock) disable iff (reset)
      job_done |=> rsp_valid_ff && rsp_data_ff.last)
      else $error("Final word of a job was not marked last.");

endmodule
